>>> rtl/met_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// met_pkg
// Shared types, constants and helpers of the escape-time pixel engine.
// -----------------------------------------------------------------------------
package met_pkg;

    // Fixed-point format: signed Q4.28 for c and z.
    localparam int Q_W       = 32;
    localparam int FRAC_BITS = 28;
    localparam int PROD_W    = 2 * Q_W;

    // Configuration register widths.
    localparam int STEP_W  = 31;
    localparam int LIMIT_W = 10;
    localparam int CFG_W   = 32;

    // Default image size in pixels along one axis.
    localparam int IMAGE_SIZE_DEF = 512;

    // Reset values of the configuration registers.
    localparam logic signed [Q_W-1:0] REAL_ORIGIN_RST = -32'sd536870912;
    localparam logic signed [Q_W-1:0] IMAG_ORIGIN_RST = -32'sd536870912;
    localparam logic [STEP_W-1:0]     COORD_STEP_RST  = 31'd2151787;
    localparam logic [LIMIT_W-1:0]    ITER_LIMIT_RST  = 10'd50;

    // Escape threshold |z|^2 >= 4.0, held in Q8.56.
    localparam logic [PROD_W-1:0] ESCAPE_SQ = 64'h0400_0000_0000_0000;

    // Saturation bounds of Q4.28, extended to product width.
    localparam logic signed [PROD_W-1:0] Q_MAX_EXT = 64'sd2147483647;
    localparam logic signed [PROD_W-1:0] Q_MIN_EXT = -64'sd2147483648;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_REAL_ORIGIN = 2'd0,
        CFG_IMAG_ORIGIN = 2'd1,
        CFG_COORD_STEP  = 2'd2,
        CFG_ITER_LIMIT  = 2'd3
    } t_cfg_idx;

    // Configuration register contents.
    typedef struct packed {
        logic signed [Q_W-1:0] real_origin;
        logic signed [Q_W-1:0] imag_origin;
        logic [STEP_W-1:0]     coord_step;
        logic [LIMIT_W-1:0]    iter_limit;
    } t_cfg;

    // Operand pairs of the shared multiplier unit.
    typedef struct packed {
        logic signed [Q_W-1:0] a0;
        logic signed [Q_W-1:0] b0;
        logic signed [Q_W-1:0] a1;
        logic signed [Q_W-1:0] b1;
        logic signed [Q_W-1:0] a2;
        logic signed [Q_W-1:0] b2;
    } t_mul_ops;

    // Registered products of the shared multiplier unit.
    typedef struct packed {
        logic signed [PROD_W-1:0] p0;
        logic signed [PROD_W-1:0] p1;
        logic signed [PROD_W-1:0] p2;
    } t_mul_prod;

    // Saturate a wide signed value to the Q4.28 range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
        logic signed [Q_W-1:0] res;
        if (v > Q_MAX_EXT) begin
            res = Q_MAX_EXT[Q_W-1:0];
        end else if (v < Q_MIN_EXT) begin
            res = Q_MIN_EXT[Q_W-1:0];
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

    // Sign-extend a Q4.28 value to product width.
    function automatic logic signed [PROD_W-1:0] sext_q(input logic signed [Q_W-1:0] v);
        return $signed({{(PROD_W-Q_W){v[Q_W-1]}}, v});
    endfunction

endpackage
`default_nettype wire

>>> rtl/met_cfg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// met_cfg
// Configuration register file: origin, step and iteration limit.
// -----------------------------------------------------------------------------
module met_cfg (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  met_pkg::t_cfg_idx           i_cfg_idx,
    input  wire logic [met_pkg::CFG_W-1:0] i_cfg_data,
    output met_pkg::t_cfg               o_cfg
);
    import met_pkg::*;

    t_cfg r_cfg;

    // Register writes, decoded by index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_origin <= REAL_ORIGIN_RST;
            r_cfg.imag_origin <= IMAG_ORIGIN_RST;
            r_cfg.coord_step  <= COORD_STEP_RST;
            r_cfg.iter_limit  <= ITER_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REAL_ORIGIN: r_cfg.real_origin <= $signed(i_cfg_data[Q_W-1:0]);
                CFG_IMAG_ORIGIN: r_cfg.imag_origin <= $signed(i_cfg_data[Q_W-1:0]);
                CFG_COORD_STEP:  r_cfg.coord_step  <= i_cfg_data[STEP_W-1:0];
                CFG_ITER_LIMIT:  r_cfg.iter_limit  <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> rtl/met_mul.sv
`default_nettype none
// -----------------------------------------------------------------------------
// met_mul
// Shared multiplier unit: three signed 32x32 products, registered.
// -----------------------------------------------------------------------------
module met_mul (
    input  wire logic         i_clk,
    input  met_pkg::t_mul_ops i_ops,
    output met_pkg::t_mul_prod o_prod
);
    import met_pkg::*;

    t_mul_prod r_prod;

    // One product per operand pair, captured every cycle.
    always_ff @(posedge i_clk) begin
        r_prod.p0 <= i_ops.a0 * i_ops.b0;
        r_prod.p1 <= i_ops.a1 * i_ops.b1;
        r_prod.p2 <= i_ops.a2 * i_ops.b2;
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

>>> rtl/met_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// met_ctrl
// Sequencer and update datapath: forms c, then steps z = z*z + c.
// -----------------------------------------------------------------------------
module met_ctrl #(
    parameter int IMAGE_SIZE = met_pkg::IMAGE_SIZE_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [$clog2(IMAGE_SIZE)-1:0] i_pixel_col,
    input  wire logic [$clog2(IMAGE_SIZE)-1:0] i_pixel_row,
    input  met_pkg::t_cfg                   i_cfg,
    output met_pkg::t_mul_ops               o_mul_ops,
    input  met_pkg::t_mul_prod              i_mul_prod,
    output logic                            o_valid,
    output logic [met_pkg::LIMIT_W-1:0]     o_iter_count,
    output logic                            o_inside_set
);
    import met_pkg::*;

    localparam int IDX_W = $clog2(IMAGE_SIZE);
    localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(IMAGE_SIZE - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMUL,
        S_CADD,
        S_MUL,
        S_UPD
    } t_state;

    t_state                r_state;
    logic [IDX_W-1:0]      r_col;
    logic [IDX_W-1:0]      r_row;
    logic signed [Q_W-1:0] r_cr;
    logic signed [Q_W-1:0] r_ci;
    logic signed [Q_W-1:0] r_zr;
    logic signed [Q_W-1:0] r_zi;
    logic [LIMIT_W-1:0]    r_count;
    logic                  r_valid;
    logic [LIMIT_W-1:0]    r_iter_count;
    logic                  r_inside;

    logic [IDX_W-1:0]         w_col_clamp;
    logic [IDX_W-1:0]         w_row_clamp;
    logic signed [Q_W-1:0]    n_cr;
    logic signed [Q_W-1:0]    n_ci;
    logic [PROD_W-1:0]        w_mag;
    logic                     w_escape;
    logic signed [PROD_W-1:0] w_diff;
    logic signed [PROD_W-1:0] w_re_sum;
    logic signed [PROD_W-1:0] w_im_sum;
    logic signed [Q_W-1:0]    n_zr;
    logic signed [Q_W-1:0]    n_zi;

    // Indexes beyond the image are held at the last pixel.
    assign w_col_clamp = (i_pixel_col > IDX_MAX) ? IDX_MAX : i_pixel_col;
    assign w_row_clamp = (i_pixel_row > IDX_MAX) ? IDX_MAX : i_pixel_row;

    // Operand selection: index times step while forming c, else z products.
    always_comb begin
        if (r_state == S_CMUL) begin
            o_mul_ops.a0 = $signed({{(Q_W-IDX_W){1'b0}}, r_col});
            o_mul_ops.b0 = $signed({1'b0, i_cfg.coord_step});
            o_mul_ops.a1 = $signed({{(Q_W-IDX_W){1'b0}}, r_row});
            o_mul_ops.b1 = $signed({1'b0, i_cfg.coord_step});
            o_mul_ops.a2 = '0;
            o_mul_ops.b2 = '0;
        end else begin
            o_mul_ops.a0 = r_zr;
            o_mul_ops.b0 = r_zr;
            o_mul_ops.a1 = r_zi;
            o_mul_ops.b1 = r_zi;
            o_mul_ops.a2 = r_zr;
            o_mul_ops.b2 = r_zi;
        end
    end

    // The point c: origin plus scaled index, saturated.
    assign n_cr = sat_q(sext_q(i_cfg.real_origin) + i_mul_prod.p0);
    assign n_ci = sat_q(sext_q(i_cfg.imag_origin) + i_mul_prod.p1);

    // Escape test on |z|^2 in Q8.56; both squares are non-negative.
    assign w_mag    = $unsigned(i_mul_prod.p0) + $unsigned(i_mul_prod.p1);
    assign w_escape = (w_mag >= ESCAPE_SQ);

    // Next z: floor back to Q4.28, add c, saturate.
    assign w_diff   = i_mul_prod.p0 - i_mul_prod.p1;
    assign w_re_sum = (w_diff >>> FRAC_BITS) + sext_q(r_cr);
    assign w_im_sum = (i_mul_prod.p2 >>> (FRAC_BITS - 1)) + sext_q(r_ci);
    assign n_zr     = sat_q(w_re_sum);
    assign n_zi     = sat_q(w_im_sum);

    // Sequencer with its working and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_col   <= w_col_clamp;
                        r_row   <= w_row_clamp;
                        r_zr    <= '0;
                        r_zi    <= '0;
                        r_count <= '0;
                        r_state <= S_CMUL;
                    end
                end
                S_CMUL: begin
                    r_state <= S_CADD;
                end
                S_CADD: begin
                    r_cr    <= n_cr;
                    r_ci    <= n_ci;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_count >= i_cfg.iter_limit) begin
                        r_valid      <= 1'b1;
                        r_iter_count <= r_count;
                        r_inside     <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_escape) begin
                        r_valid      <= 1'b1;
                        r_iter_count <= r_count;
                        r_inside     <= (r_count == i_cfg.iter_limit);
                        r_state      <= S_IDLE;
                    end else begin
                        r_zr    <= n_zr;
                        r_zi    <= n_zi;
                        r_count <= r_count + 1'b1;
                        r_state <= S_MUL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_iter_count = r_iter_count;
    assign o_inside_set = r_inside;

endmodule
`default_nettype wire

>>> rtl/mandelbrot_escape_time_top.sv
`default_nettype none
// A request ends when the point escapes or when the iteration limit is reached.
// One request is worked at a time; busy falls in the cycle the result strobe is
// high, so the next request may start then. Each iteration passes through the
// shared multiplier in state S_MUL and then the update in state S_UPD. The result
// is strobed for one cycle and cannot be stalled. Reset is synchronous and
// restores the state, the result strobe and the configuration registers.
// -----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// Escape-time pixel engine in signed Q4.28 with a shared multiplier unit.
// -----------------------------------------------------------------------------
module mandelbrot_escape_time_top #(
    parameter int IMAGE_SIZE = met_pkg::IMAGE_SIZE_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  met_pkg::t_cfg_idx                  i_cfg_idx,
    input  wire logic [met_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [$clog2(IMAGE_SIZE)-1:0] i_pixel_col,
    input  wire logic [$clog2(IMAGE_SIZE)-1:0] i_pixel_row,
    output logic                               o_valid,
    output logic [met_pkg::LIMIT_W-1:0]        o_iter_count,
    output logic                               o_inside_set
);
    import met_pkg::*;

    t_cfg      w_cfg;
    t_mul_ops  w_mul_ops;
    t_mul_prod w_mul_prod;

    // Configuration registers.
    met_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Shared multiplier unit.
    met_mul u_mul (
        .i_clk  (i_clk),
        .i_ops  (w_mul_ops),
        .o_prod (w_mul_prod)
    );

    // Sequencer and update datapath.
    met_ctrl #(
        .IMAGE_SIZE (IMAGE_SIZE)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_pixel_col  (i_pixel_col),
        .i_pixel_row  (i_pixel_row),
        .i_cfg        (w_cfg),
        .o_mul_ops    (w_mul_ops),
        .i_mul_prod   (w_mul_prod),
        .o_valid      (o_valid),
        .o_iter_count (o_iter_count),
        .o_inside_set (o_inside_set)
    );

endmodule
`default_nettype wire
